/* rtl/core/adsr_pkg.sv */
// shared widths, constants and types of the envelope generator
package adsr_pkg;

	// tick counter and amplitude widths
	localparam int COUNT_W = 24;
	localparam int AMP_W   = 16;

	// step counter of the serial multiply/divide, one step per amplitude bit
	localparam int STEP_W = $clog2(AMP_W);

	// amplitudes at or below this floor read as silence
	localparam logic [AMP_W-1:0] AMP_FLOOR = AMP_W'((2 ** AMP_W) / 10000);

	// gate event codes, the spare code acts as no event
	typedef enum logic [1:0] {
		EV_NONE,
		EV_NOTE_ON,
		EV_NOTE_OFF,
		EV_SPARE
	} gate_event_t;

	// envelope stage codes
	typedef enum logic [1:0] {
		STAGE_ATTACK,
		STAGE_DECAY,
		STAGE_SUSTAIN,
		STAGE_RELEASE
	} stage_t;

	// configuration register indexes
	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_DECAY   = 3'd1;
	localparam logic [2:0] REG_RELEASE = 3'd2;
	localparam logic [2:0] REG_PEAK    = 3'd3;
	localparam logic [2:0] REG_SUSTAIN = 3'd4;

	// request to the serial multiply/divide unit: count * level / divisor
	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] count;
		logic [AMP_W-1:0]   level;
		logic [COUNT_W-1:0] divisor;
	} md_req_t;

endpackage

/* rtl/core/adsr_muldiv.sv */
// radix-2 shift-add multiply followed by restoring divide, one bit per cycle
module adsr_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  adsr_pkg::md_req_t req,
	output logic             done,
	output logic [adsr_pkg::AMP_W-1:0] quot
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV
	} phase_t;

	localparam logic [adsr_pkg::STEP_W-1:0] STEP_LAST =
		adsr_pkg::STEP_W'(adsr_pkg::AMP_W - 1);

	phase_t                          phase_q;
	logic [adsr_pkg::STEP_W-1:0]     step_q;
	logic                            done_q;
	logic [adsr_pkg::COUNT_W-1:0]    hi_q;
	logic [adsr_pkg::AMP_W-1:0]      lo_q;
	logic [adsr_pkg::COUNT_W-1:0]    mcand_q;
	logic [adsr_pkg::COUNT_W-1:0]    div_q;

	logic [adsr_pkg::COUNT_W:0]      mul_sum;
	logic [adsr_pkg::COUNT_W:0]      trial;
	logic [adsr_pkg::COUNT_W+1:0]    diff;
	logic                            ge;

	// multiply step: add multiplicand when the low multiplier bit is set
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// divide step: shift in next dividend bit, subtract when it fits
	assign trial = {hi_q, lo_q[adsr_pkg::AMP_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign ge    = ~diff[adsr_pkg::COUNT_W+1];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_MUL;
						step_q  <= '0;
					end
				end
				PH_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						phase_q <= PH_DIV;
						step_q  <= '0;
					end
				end
				PH_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						phase_q <= PH_IDLE;
						step_q  <= '0;
						done_q  <= 1'b1;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// datapath: hi holds the upper product, then the remainder; lo the multiplier, then the quotient
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					hi_q    <= '0;
					lo_q    <= req.level;
					mcand_q <= req.count;
					div_q   <= req.divisor;
				end
			end
			PH_MUL: begin
				hi_q <= mul_sum[adsr_pkg::COUNT_W:1];
				lo_q <= {mul_sum[0], lo_q[adsr_pkg::AMP_W-1:1]};
			end
			PH_DIV: begin
				hi_q <= ge ? diff[adsr_pkg::COUNT_W-1:0] : trial[adsr_pkg::COUNT_W-1:0];
				lo_q <= {lo_q[adsr_pkg::AMP_W-2:0], ge};
			end
			default: begin
				hi_q <= hi_q;
			end
		endcase
	end

	assign done = done_q;
	assign quot = lo_q;

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> phase_q == PH_IDLE)
		else $error("muldiv started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("muldiv done held longer than one cycle");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIV |-> hi_q < div_q)
		else $error("muldiv remainder not below divisor, quotient overflow");

endmodule

/* rtl/core/adsr_envelope_generator.sv */
// linear adsr envelope generator top level
// Usage:
//   Input channel (in_valid/in_stall, gate_event): one transaction per sample
//   tick, carrying none, note on or note off. The event is applied, one
//   amplitude/stage result is produced, then both tick counters advance.
//   Output channel (out_valid/out_stall, amplitude, stage): one transaction
//   per input tick, in order. amplitude is unsigned Q0.16.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0..4 selects attack, decay, release ticks, peak, sustain level.
//   Write only while idle; other indexes are ignored.
// Timing:
//   One tick is processed at a time. A ramp tick (attack, decay, release)
//   has its result after setup, start of the serial unit, the shift-add
//   multiply, the restoring divide, then the combine and the output load.
//   Flat ticks (zero attack, sustain, release ended or zero release length)
//   go from setup straight to the finish state and the output load.
//   The next tick is accepted the cycle after the result is loaded; the
//   serial unit sets the rate.
// Reset: gate released, counters at zero (release from sustain level),
//   registers at their defaults, no result pending.
// Stall: a held result stays in the output register; the next tick is still
//   computed and waits until the register frees up.
module adsr_envelope_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 gate_event,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [adsr_pkg::AMP_W-1:0] amplitude,
	output logic [1:0]                 stage,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [23:0]                cfg_data
);

	localparam int CW = adsr_pkg::COUNT_W;
	localparam int AW = adsr_pkg::AMP_W;

	// register defaults
	localparam logic [CW-1:0] ATTACK_RST  = CW'(4410);
	localparam logic [CW-1:0] DECAY_RST   = CW'(441);
	localparam logic [CW-1:0] RELEASE_RST = CW'(8820);
	localparam logic [AW-1:0] PEAK_RST    = AW'(65535);
	localparam logic [AW-1:0] SUSTAIN_RST = AW'(52429);

	localparam logic [CW-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP,
		S_CALC,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       attack_q;
	logic [CW-1:0]       decay_q;
	logic [CW-1:0]       release_q;
	logic [AW-1:0]       peak_q;
	logic [AW-1:0]       sustain_q;
	logic                gate_q;
	logic [CW-1:0]       on_q;
	logic [CW-1:0]       off_q;
	logic                out_valid_q;
	logic [AW-1:0]       amp_out_q;
	adsr_pkg::stage_t    stage_out_q;
	adsr_pkg::stage_t    stage_q;
	logic [AW-1:0]       amp_q;
	logic [AW-1:0]       base_q;
	logic                add_q;
	adsr_pkg::md_req_t   req_q;

	logic                md_done;
	logic [AW-1:0]       md_quot;

	logic                life_le_a;
	logic [CW:0]         sum_ad;
	logic                life_le_ad;
	logic                off_ge_r;
	logic                p_ge_s;
	logic [CW-1:0]       life_minus_a;
	logic [AW-1:0]       decay_span;
	logic                in_acc;
	logic                out_free;

	// stage selection compares
	assign life_le_a    = on_q <= attack_q;
	assign sum_ad       = {1'b0, attack_q} + {1'b0, decay_q};
	assign life_le_ad   = {1'b0, on_q} <= sum_ad;
	assign off_ge_r     = off_q >= release_q;
	assign p_ge_s       = peak_q >= sustain_q;
	assign life_minus_a = on_q - attack_q;
	assign decay_span   = p_ge_s ? (peak_q - sustain_q) : (sustain_q - peak_q);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			release_q <= RELEASE_RST;
			peak_q    <= PEAK_RST;
			sustain_q <= SUSTAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				adsr_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				adsr_pkg::REG_DECAY:   decay_q   <= cfg_data;
				adsr_pkg::REG_RELEASE: release_q <= cfg_data;
				adsr_pkg::REG_PEAK:    peak_q    <= cfg_data[AW-1:0];
				adsr_pkg::REG_SUSTAIN: sustain_q <= cfg_data[AW-1:0];
				default: begin
					attack_q <= attack_q;
				end
			endcase
		end
	end

	// tick sequencer, gate state, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gate_q      <= 1'b0;
			on_q        <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
			req_q.start <= 1'b0;
		end else begin
			// output register empties when taken, unless a result is loaded now
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (gate_event == adsr_pkg::EV_NOTE_ON) begin
							gate_q <= 1'b1;
							on_q   <= '0;
						end else if (gate_event == adsr_pkg::EV_NOTE_OFF) begin
							gate_q <= 1'b0;
							off_q  <= '0;
						end
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (gate_q) begin
						if (life_le_a) begin
							stage_q <= adsr_pkg::STAGE_ATTACK;
							if (attack_q == '0) begin
								amp_q   <= peak_q;
								state_q <= S_FINISH;
							end else begin
								req_q.start   <= 1'b1;
								req_q.count   <= on_q;
								req_q.level   <= peak_q;
								req_q.divisor <= attack_q;
								base_q        <= '0;
								add_q         <= 1'b1;
								state_q       <= S_CALC;
							end
						end else if (life_le_ad) begin
							stage_q       <= adsr_pkg::STAGE_DECAY;
							req_q.start   <= 1'b1;
							req_q.count   <= life_minus_a;
							req_q.level   <= decay_span;
							req_q.divisor <= decay_q;
							base_q        <= peak_q;
							add_q         <= !p_ge_s;
							state_q       <= S_CALC;
						end else begin
							stage_q <= adsr_pkg::STAGE_SUSTAIN;
							amp_q   <= sustain_q;
							state_q <= S_FINISH;
						end
					end else begin
						stage_q <= adsr_pkg::STAGE_RELEASE;
						if (off_ge_r) begin
							// ramp finished, or zero release length
							amp_q   <= '0;
							state_q <= S_FINISH;
						end else begin
							req_q.start   <= 1'b1;
							req_q.count   <= off_q;
							req_q.level   <= sustain_q;
							req_q.divisor <= release_q;
							base_q        <= sustain_q;
							add_q         <= 1'b0;
							state_q       <= S_CALC;
						end
					end
				end
				S_CALC: begin
					req_q.start <= 1'b0;
					if (md_done) begin
						amp_q   <= add_q ? (base_q + md_quot) : (base_q - md_quot);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						amp_out_q   <= (amp_q <= adsr_pkg::AMP_FLOOR) ? '0 : amp_q;
						stage_out_q <= stage_q;
						on_q        <= (on_q == COUNT_MAX) ? on_q : on_q + 1'b1;
						off_q       <= (off_q == COUNT_MAX) ? off_q : off_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// serial multiply/divide unit
	adsr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign out_valid = out_valid_q;
	assign amplitude = amp_out_q;
	assign stage     = stage_out_q;

	// checks
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_SETUP)
		else $error("accepted tick did not enter setup");

	a_amp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (amp_out_q == '0 || amp_out_q > adsr_pkg::AMP_FLOOR))
		else $error("amplitude at or below floor not cleared");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == S_CALC)
		else $error("muldiv result arrived outside calc state");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished tick not loaded into output register");

endmodule
